// ===== rtl/scfp_pkg.sv =====
package scfp_pkg;

  // Frame delimiters and opcodes
  localparam logic [7:0] SOF_BYTE     = 8'h7B;
  localparam logic [7:0] EOF_BYTE     = 8'h7D;
  localparam logic [7:0] OP_MOTION    = 8'h00;
  localparam logic [7:0] OP_CHARGE    = 8'h01;
  localparam logic [7:0] OP_DOCK      = 8'h02;
  localparam logic [7:0] OP_VEL_LIMIT = 8'h03;
  localparam logic [7:0] OP_LIGHT     = 8'h04;
  localparam logic [7:0] OP_ADDR      = 8'hFF;
  localparam logic [7:0] LIGHT_ON_ARG = 8'h01;
  localparam logic [7:0] CNT_MAX      = 8'hFF;

  // Result kinds
  localparam logic [2:0] KIND_MOTION = 3'd0;
  localparam logic [2:0] KIND_CHARGE = 3'd1;
  localparam logic [2:0] KIND_LIGHT  = 3'd2;
  localparam logic [2:0] KIND_OTHER  = 3'd3;
  localparam logic [2:0] KIND_ADDR   = 3'd4;

  // Configuration registers
  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t CFG_IDLE_LIMIT      = 1'b0;
  localparam cfg_idx_t CFG_CONFIRM_REPEATS = 1'b1;
  localparam logic [7:0] IDLE_LIMIT_RST    = 8'd10;
  localparam logic [7:0] CONFIRM_RST       = 8'd50;

  // Checked frame handed from the assembler to the decoder
  typedef struct packed {
    logic [7:0]  op;
    logic [7:0]  arg;
    logic [47:0] body;   // bytes 3..8, byte 3 in bits 47..40
  } frame_t;

  typedef struct packed {
    logic [2:0]         frame_kind;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] vel_z;
    logic               send_velocity;
    logic               charge_mode;
    logic [7:0]         security_level;
    logic               light_enable;
    logic [23:0]        light_rgb;
    logic [31:0]        confirmed_addr;
    logic               addr_valid;
  } result_t;

endpackage

// ===== rtl/scfp_if.sv =====
interface scfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface scfp_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         frame_kind;
  logic signed [15:0] vel_x;
  logic signed [15:0] vel_y;
  logic signed [15:0] vel_z;
  logic               send_velocity;
  logic               charge_mode;
  logic [7:0]         security_level;
  logic               light_enable;
  logic [23:0]        light_rgb;
  logic [31:0]        confirmed_addr;
  logic               addr_valid;

  modport source (output valid, output frame_kind, output vel_x, output vel_y,
                  output vel_z, output send_velocity, output charge_mode,
                  output security_level, output light_enable, output light_rgb,
                  output confirmed_addr, output addr_valid, input ready);
  modport sink   (input valid, input frame_kind, input vel_x, input vel_y,
                  input vel_z, input send_velocity, input charge_mode,
                  input security_level, input light_enable, input light_rgb,
                  input confirmed_addr, input addr_valid, output ready);
endinterface

// ===== rtl/serial_command_frame_parser_unit.sv =====
// Serial command frame parser: takes one received byte per cycle on in_ch while
// in_ch.ready is high and gives one request on out_ch for every FRAME_LEN-byte
// frame that opens with 0x7B, closes with 0x7D and carries a correct XOR check
// byte; all other bytes and rejected frames give nothing. The result of a good
// frame passes through the frame register of the assembler and then the result
// register of the decoder. in_ch.ready drops only while both of those registers
// are full and out_ch is stalled. Settings (charge, security, light, idle run,
// address confirmation) reflect the frame just reported. cfg_idx 0 writes
// idle_limit (reset 10), cfg_idx 1 writes confirm_repeats (reset 50); write them
// only while the block is idle.
module serial_command_frame_parser_unit #(
  parameter int FRAME_LEN = 11
) (
  input  logic                clk,
  input  logic                rst_n,
  scfp_in_if.sink             in_ch,
  scfp_out_if.source          out_ch,
  input  logic                cfg_we,
  input  scfp_pkg::cfg_idx_t  cfg_idx,
  input  logic [7:0]          cfg_wdata
);
  import scfp_pkg::*;

  logic [7:0] idle_lim_r;
  logic [7:0] confirm_r;
  logic       frm_vld;
  frame_t     frm;
  logic       take;
  logic       byte_vld;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_lim_r <= IDLE_LIMIT_RST;
      confirm_r  <= CONFIRM_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_IDLE_LIMIT:      idle_lim_r <= cfg_wdata;
        CFG_CONFIRM_REPEATS: confirm_r  <= cfg_wdata;
        default:             idle_lim_r <= idle_lim_r;
      endcase
    end
  end

  assign in_ch.ready  = ~frm_vld | take;
  assign byte_vld     = in_ch.valid & in_ch.ready;

  scfp_assembler #(
    .FRAME_LEN (FRAME_LEN)
  ) u_asm (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_vld (byte_vld),
    .byte_in  (in_ch.rx_byte),
    .take     (take),
    .frm_vld  (frm_vld),
    .frm      (frm)
  );

  scfp_decoder u_dec (
    .clk             (clk),
    .rst_n           (rst_n),
    .frm_vld         (frm_vld),
    .frm             (frm),
    .idle_limit      (idle_lim_r),
    .confirm_repeats (confirm_r),
    .take            (take),
    .out_ch          (out_ch)
  );

endmodule

// ===== rtl/scfp_assembler.sv =====
module scfp_assembler #(
  parameter int FRAME_LEN = 11
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             byte_vld,
  input  logic [7:0]       byte_in,
  input  logic             take,
  output logic             frm_vld,
  output scfp_pkg::frame_t frm
);
  import scfp_pkg::*;

  localparam int IDX_W = $clog2(FRAME_LEN);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(FRAME_LEN - 1);
  localparam logic [IDX_W-1:0] IDX_CHECK = IDX_W'(FRAME_LEN - 2);

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]       bcc_r, bcc_nxt;
  logic [7:0]       store_r [FRAME_LEN];
  logic             frm_vld_r, frm_vld_nxt;
  frame_t           frm_r, frm_nxt;
  logic [7:0]       bcc_base;
  logic             frame_ok;

  // Track position, running check byte and completion of a good frame
  always_comb begin
    bcc_base    = (idx_r == '0) ? 8'h00 : bcc_r;
    bcc_nxt     = bcc_r;
    idx_nxt     = idx_r;
    frm_vld_nxt = frm_vld_r & ~take;
    frm_nxt     = frm_r;
    frame_ok    = (byte_in == EOF_BYTE) && (store_r[IDX_CHECK] == bcc_r);
    if (byte_vld) begin
      bcc_nxt = (idx_r < IDX_CHECK) ? (bcc_base ^ byte_in) : bcc_base;
      if (idx_r == '0 && byte_in != SOF_BYTE) begin
        idx_nxt = '0;
      end else if (idx_r != IDX_LAST) begin
        idx_nxt = idx_r + 1'b1;
      end else begin
        idx_nxt = '0;
        if (frame_ok) begin
          frm_vld_nxt  = 1'b1;
          frm_nxt.op   = store_r[1];
          frm_nxt.arg  = store_r[2];
          frm_nxt.body = {store_r[3], store_r[4], store_r[5],
                          store_r[6], store_r[7], store_r[8]};
        end
      end
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      bcc_r     <= 8'h00;
      frm_vld_r <= 1'b0;
    end else begin
      idx_r     <= idx_nxt;
      bcc_r     <= bcc_nxt;
      frm_vld_r <= frm_vld_nxt;
    end
  end

  // Store bytes and the captured frame
  always_ff @(posedge clk) begin
    if (byte_vld) begin
      store_r[idx_r] <= byte_in;
    end
    frm_r <= frm_nxt;
  end

  assign frm_vld = frm_vld_r;
  assign frm     = frm_r;

endmodule

// ===== rtl/scfp_decoder.sv =====
module scfp_decoder (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             frm_vld,
  input  scfp_pkg::frame_t frm,
  input  logic [7:0]       idle_limit,
  input  logic [7:0]       confirm_repeats,
  output logic             take,
  scfp_out_if.source       out_ch
);
  import scfp_pkg::*;

  logic        charge_r, charge_nxt;
  logic [7:0]  security_r, security_nxt;
  logic        light_on_r, light_on_nxt;
  logic [23:0] colour_r, colour_nxt;
  logic [7:0]  idle_run_r, idle_run_nxt;
  logic [31:0] last_addr_r, last_addr_nxt;
  logic [7:0]  repeat_r, repeat_nxt;
  logic [31:0] addr_conf_r, addr_conf_nxt;
  logic        addr_ok_r, addr_ok_nxt;
  logic        out_vld_r, out_vld_nxt;
  result_t     res_r, res_nxt;

  logic [31:0]        addr;
  logic [7:0]         rc_inc;
  logic [7:0]         idle_inc;
  logic               vel_ok;
  logic signed [15:0] vx, vy, vz;
  logic [2:0]         kind;
  logic               send;

  assign take = frm_vld & (~out_vld_r | out_ch.ready);

  // Decode a checked frame, update settings and form the result
  always_comb begin
    addr     = frm.body[47:16];
    rc_inc   = (repeat_r == CNT_MAX) ? repeat_r : repeat_r + 8'd1;
    vel_ok   = frm.op < OP_VEL_LIMIT;
    vx       = vel_ok ? frm.body[47:32] : 16'sd0;
    vy       = vel_ok ? frm.body[31:16] : 16'sd0;
    vz       = vel_ok ? frm.body[15:0]  : 16'sd0;
    idle_inc = (vx == 16'sd0 && vy == 16'sd0 && vz == 16'sd0) ?
               ((idle_run_r == CNT_MAX) ? idle_run_r : idle_run_r + 8'd1) : 8'd0;
    send     = 1'b1;
    kind     = KIND_OTHER;

    charge_nxt    = charge_r;
    security_nxt  = security_r;
    light_on_nxt  = light_on_r;
    colour_nxt    = colour_r;
    idle_run_nxt  = idle_run_r;
    last_addr_nxt = last_addr_r;
    repeat_nxt    = repeat_r;
    addr_conf_nxt = addr_conf_r;
    addr_ok_nxt   = addr_ok_r;

    if (frm.op == OP_ADDR) begin
      kind = KIND_ADDR;
      send = 1'b0;
      if (addr == last_addr_r) begin
        repeat_nxt = rc_inc;
        if (rc_inc >= confirm_repeats) begin
          addr_conf_nxt = addr;
          addr_ok_nxt   = 1'b1;
        end
      end else begin
        repeat_nxt    = 8'd1;
        last_addr_nxt = addr;
      end
    end else begin
      if (frm.op == OP_MOTION) begin
        kind         = KIND_MOTION;
        charge_nxt   = 1'b0;
        security_nxt = frm.arg;
      end else if (frm.op == OP_CHARGE || frm.op == OP_DOCK) begin
        kind       = KIND_CHARGE;
        charge_nxt = 1'b1;
      end else if (frm.op == OP_LIGHT) begin
        kind = KIND_LIGHT;
        if (frm.arg == LIGHT_ON_ARG) begin
          light_on_nxt = 1'b1;
          colour_nxt   = frm.body[47:24];
        end else begin
          light_on_nxt = 1'b0;
        end
      end
      // Suppress the send after too many idle frames in a row
      if (idle_inc > idle_limit) begin
        send         = 1'b0;
        idle_run_nxt = idle_limit;
      end else begin
        idle_run_nxt = idle_inc;
      end
    end

    res_nxt.frame_kind     = kind;
    res_nxt.vel_x          = (frm.op == OP_ADDR) ? 16'sd0 : vx;
    res_nxt.vel_y          = (frm.op == OP_ADDR) ? 16'sd0 : vy;
    res_nxt.vel_z          = (frm.op == OP_ADDR) ? 16'sd0 : vz;
    res_nxt.send_velocity  = send;
    res_nxt.charge_mode    = charge_nxt;
    res_nxt.security_level = security_nxt;
    res_nxt.light_enable   = light_on_nxt;
    res_nxt.light_rgb      = colour_nxt;
    res_nxt.confirmed_addr = addr_conf_nxt;
    res_nxt.addr_valid     = addr_ok_nxt;

    out_vld_nxt = take | (out_vld_r & ~out_ch.ready);
  end

  // Advance settings and the result register on a taken frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      charge_r    <= 1'b0;
      security_r  <= 8'h00;
      light_on_r  <= 1'b0;
      colour_r    <= 24'h0;
      idle_run_r  <= 8'h00;
      last_addr_r <= 32'h0;
      repeat_r    <= 8'h00;
      addr_conf_r <= 32'h0;
      addr_ok_r   <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
      if (take) begin
        charge_r    <= charge_nxt;
        security_r  <= security_nxt;
        light_on_r  <= light_on_nxt;
        colour_r    <= colour_nxt;
        idle_run_r  <= idle_run_nxt;
        last_addr_r <= last_addr_nxt;
        repeat_r    <= repeat_nxt;
        addr_conf_r <= addr_conf_nxt;
        addr_ok_r   <= addr_ok_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.frame_kind     = res_r.frame_kind;
  assign out_ch.vel_x          = res_r.vel_x;
  assign out_ch.vel_y          = res_r.vel_y;
  assign out_ch.vel_z          = res_r.vel_z;
  assign out_ch.send_velocity  = res_r.send_velocity;
  assign out_ch.charge_mode    = res_r.charge_mode;
  assign out_ch.security_level = res_r.security_level;
  assign out_ch.light_enable   = res_r.light_enable;
  assign out_ch.light_rgb      = res_r.light_rgb;
  assign out_ch.confirmed_addr = res_r.confirmed_addr;
  assign out_ch.addr_valid     = res_r.addr_valid;

endmodule

// ===== dv/tb_serial_command_frame_parser_unit.sv =====
`timescale 1ns / 1ps

module tb_serial_command_frame_parser_unit;
  import scfp_pkg::*;

  localparam int FRAME_LEN    = 11;
  localparam int MAX_REPORTS  = 10;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_RUN     = 2;

  typedef enum logic [1:0] {FLAW_NONE, FLAW_END, FLAW_CHECK} flaw_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  cfg_idx_t   cfg_idx;
  logic [7:0] cfg_wdata;

  scfp_in_if  in_ch ();
  scfp_out_if out_ch ();

  serial_command_frame_parser_unit #(.FRAME_LEN(FRAME_LEN)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // Byte stream waiting for the driver and frame results waiting for the block
  logic [7:0]  tx_bytes [$];
  result_t     pending_results [$];
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  logic        in_fire;
  int          mismatches = 0;
  logic [31:0] addr_pool [3];

  // Mirror of the parser state
  logic [7:0]  frame_buf [FRAME_LEN];
  int unsigned rx_pos;
  logic [7:0]  chk_xor;
  logic        charge_q;
  logic [7:0]  sec_level_q;
  logic        light_q;
  logic [23:0] colour_q;
  logic [7:0]  idle_cnt;
  logic [31:0] prev_addr;
  logic [7:0]  addr_hits;
  logic [31:0] addr_q;
  logic        addr_seen;
  logic [7:0]  idle_lim_q;
  logic [7:0]  confirm_q;
  result_t     got;
  result_t     want;
  result_t     next_res;

  always #1 clk = ~clk;

  // Advance the frame mirror by one byte; return 1 when a frame result is due
  function automatic bit decode_byte(input logic [7:0] b, output result_t r);
    int unsigned pos;
    logic [7:0]  op;
    logic [15:0] vx;
    logic [15:0] vy;
    logic [15:0] vz;
    logic [31:0] a;
    logic [2:0]  kind;
    logic        send;
    r    = '0;
    vx   = '0;
    vy   = '0;
    vz   = '0;
    send = 1'b1;
    pos  = (rx_pos >= FRAME_LEN) ? 0 : rx_pos;
    frame_buf[pos] = b;
    if (pos == 0) chk_xor = '0;
    if (pos < FRAME_LEN - 2) chk_xor ^= b;
    // drop stray bytes between frames
    if (pos == 0 && b != SOF_BYTE) begin
      rx_pos = 0;
      return 1'b0;
    end
    pos++;
    if (pos < FRAME_LEN) begin
      rx_pos = pos;
      return 1'b0;
    end
    rx_pos = 0;
    // drop frames with a bad end or check byte
    if (frame_buf[FRAME_LEN-1] != EOF_BYTE || frame_buf[FRAME_LEN-2] != chk_xor)
      return 1'b0;
    op = frame_buf[1];
    if (op == OP_ADDR) begin
      a = {frame_buf[3], frame_buf[4], frame_buf[5], frame_buf[6]};
      if (a == prev_addr) begin
        if (addr_hits != CNT_MAX) addr_hits++;
        if (addr_hits >= confirm_q) begin
          addr_q    = a;
          addr_seen = 1'b1;
        end
      end else begin
        addr_hits = 8'd1;
        prev_addr = a;
      end
      kind = KIND_ADDR;
      send = 1'b0;
    end else begin
      if (op < OP_VEL_LIMIT) begin
        vx = {frame_buf[3], frame_buf[4]};
        vy = {frame_buf[5], frame_buf[6]};
        vz = {frame_buf[7], frame_buf[8]};
      end
      if (op == OP_MOTION) begin
        charge_q    = 1'b0;
        sec_level_q = frame_buf[2];
        kind        = KIND_MOTION;
      end else if (op == OP_CHARGE || op == OP_DOCK) begin
        charge_q = 1'b1;
        kind     = KIND_CHARGE;
      end else if (op == OP_LIGHT) begin
        if (frame_buf[2] == LIGHT_ON_ARG) begin
          light_q  = 1'b1;
          colour_q = {frame_buf[3], frame_buf[4], frame_buf[5]};
        end else begin
          light_q = 1'b0;
        end
        kind = KIND_LIGHT;
      end else begin
        kind = KIND_OTHER;
      end
      // count idle frames, suppress the send once past the limit
      if (vx == 0 && vy == 0 && vz == 0) begin
        if (idle_cnt != CNT_MAX) idle_cnt++;
      end else begin
        idle_cnt = '0;
      end
      if (idle_cnt > idle_lim_q) begin
        send     = 1'b0;
        idle_cnt = idle_lim_q;
      end
    end
    r.frame_kind     = kind;
    r.vel_x          = vx;
    r.vel_y          = vy;
    r.vel_z          = vz;
    r.send_velocity  = send;
    r.charge_mode    = charge_q;
    r.security_level = sec_level_q;
    r.light_enable   = light_q;
    r.light_rgb      = colour_q;
    r.confirmed_addr = addr_q;
    r.addr_valid     = addr_seen;
    return 1'b1;
  endfunction

  function automatic string fmt_result(input result_t r);
    return $sformatf({"kind=%0d vel=(%0d,%0d,%0d) send=%0b charge=%0b sec=%02h ",
                      "light=%0b rgb=%06h addr=%08h valid=%0b"},
                     r.frame_kind, r.vel_x, r.vel_y, r.vel_z, r.send_velocity,
                     r.charge_mode, r.security_level, r.light_enable, r.light_rgb,
                     r.confirmed_addr, r.addr_valid);
  endfunction

  function automatic logic [15:0] pick_vel();
    case ($urandom_range(5))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'hFFFF;
      3:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Queue one frame with a correct check byte, optionally broken
  task automatic push_frame(input logic [7:0] op, input logic [7:0] arg,
                            input logic [47:0] body, input flaw_t flaw);
    logic [7:0] fb [FRAME_LEN];
    logic [7:0] bcc;
    fb[0] = SOF_BYTE;
    fb[1] = op;
    fb[2] = arg;
    for (int i = 0; i < 6; i++) fb[3+i] = body[47-8*i -: 8];
    bcc = '0;
    for (int i = 0; i < FRAME_LEN - 2; i++) bcc ^= fb[i];
    fb[FRAME_LEN-2] = bcc;
    fb[FRAME_LEN-1] = EOF_BYTE;
    if (flaw == FLAW_END) fb[FRAME_LEN-1] ^= 8'($urandom_range(1, 255));
    else if (flaw == FLAW_CHECK) fb[FRAME_LEN-2] ^= 8'($urandom_range(1, 255));
    foreach (fb[i]) tx_bytes.push_back(fb[i]);
  endtask

  // Mostly good frames with random content, some broken ones and line noise
  task automatic push_random_frame();
    int unsigned sel;
    int unsigned f;
    logic [7:0]  op;
    logic [7:0]  arg;
    logic [47:0] body;
    logic [31:0] a;
    flaw_t       flaw;
    sel  = $urandom_range(99);
    arg  = 8'($urandom);
    body = {pick_vel(), pick_vel(), pick_vel()};
    if (sel < 28) begin
      op = OP_MOTION;
    end else if (sel < 44) begin
      op = ($urandom_range(1) == 0) ? OP_CHARGE : OP_DOCK;
    end else if (sel < 54) begin
      op = OP_VEL_LIMIT;
    end else if (sel < 68) begin
      op = OP_LIGHT;
      if ($urandom_range(1) == 0) arg = LIGHT_ON_ARG;
    end else if (sel < 88) begin
      op = OP_ADDR;
      a  = ($urandom_range(9) == 0) ? 32'($urandom) : addr_pool[$urandom_range(2)];
      body = {a, 16'($urandom)};
    end else begin
      op = 8'($urandom);
    end
    if (op != OP_ADDR && $urandom_range(2) == 0) body = '0;
    f = $urandom_range(99);
    if (f < 7) flaw = FLAW_END;
    else if (f < 14) flaw = FLAW_CHECK;
    else flaw = FLAW_NONE;
    if ($urandom_range(19) == 0)
      repeat ($urandom_range(1, 4)) tx_bytes.push_back(8'($urandom));
    push_frame(op, arg, body, flaw);
  endtask

  // Wait until every byte is taken and every result has come back
  task automatic settle();
    while (tx_bytes.size() != 0 || in_ch.valid) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
  endtask

  task automatic run_phase(input logic [7:0] idle_lim, input logic [7:0] confirm,
                           input int unsigned idle_pct, input int unsigned stall,
                           input int frames);
    settle();
    write_reg(CFG_IDLE_LIMIT, idle_lim);
    write_reg(CFG_CONFIRM_REPEATS, confirm);
    @(negedge clk) cfg_we <= 1'b0;
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    repeat (frames) push_random_frame();
  endtask

  // Driver: present the next byte once the current request is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      if (tx_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid   <= 1'b1;
        in_ch.rx_byte <= tx_bytes.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Monitor: mirror register writes, predict on accepted bytes, check results
  always @(posedge clk) begin
    if (!rst_n) begin
      in_fire <= 1'b0;
      foreach (frame_buf[i]) frame_buf[i] = '0;
      rx_pos      = 0;
      chk_xor     = '0;
      charge_q    = 1'b0;
      sec_level_q = '0;
      light_q     = 1'b0;
      colour_q    = '0;
      idle_cnt    = '0;
      prev_addr   = '0;
      addr_hits   = '0;
      addr_q      = '0;
      addr_seen   = 1'b0;
      idle_lim_q  = IDLE_LIMIT_RST;
      confirm_q   = CONFIRM_RST;
    end else begin
      in_fire <= in_ch.valid && in_ch.ready;
      if (cfg_we) begin
        if (cfg_idx == CFG_IDLE_LIMIT) idle_lim_q = cfg_wdata;
        else confirm_q = cfg_wdata;
      end
      if (in_ch.valid && in_ch.ready) begin
        if (decode_byte(in_ch.rx_byte, next_res)) pending_results.push_back(next_res);
      end
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.frame_kind, out_ch.vel_x, out_ch.vel_y, out_ch.vel_z,
               out_ch.send_velocity, out_ch.charge_mode, out_ch.security_level,
               out_ch.light_enable, out_ch.light_rgb, out_ch.confirmed_addr,
               out_ch.addr_valid};
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected frame result: %s", fmt_result(got));
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("frame result differs\n  expected %s\n  actual   %s",
                       fmt_result(want), fmt_result(got));
          end
        end
      end
    end
  end

  // Stimulus
  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = CFG_IDLE_LIMIT;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = '0;
    out_ch.ready  = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    addr_pool[0]  = '0;
    addr_pool[1]  = $urandom;
    addr_pool[2]  = $urandom;
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // noise outside a frame
    tx_bytes.push_back(8'h00);
    tx_bytes.push_back(8'hFF);
    tx_bytes.push_back(EOF_BYTE);
    // velocity extremes
    push_frame(OP_MOTION, 8'hFF, {16'h8000, 16'h7FFF, 16'hFFFF}, FLAW_NONE);
    push_frame(OP_MOTION, 8'h00, {16'h7FFF, 16'h8000, 16'h0001}, FLAW_NONE);
    push_frame(OP_CHARGE, 8'h5A, {16'h0000, 16'h0000, 16'h0100}, FLAW_NONE);
    push_frame(OP_DOCK, 8'hA5, 48'h0, FLAW_NONE);
    // opcode 3 reports zero velocity even with a full body
    push_frame(OP_VEL_LIMIT, 8'h01, 48'hFFFF_FFFF_FFFF, FLAW_NONE);
    // light on, off keeping the colour, on with black
    push_frame(OP_LIGHT, LIGHT_ON_ARG, {24'hFFFFFF, 24'h123456}, FLAW_NONE);
    push_frame(OP_LIGHT, 8'h00, {24'h00FF00, 24'h0}, FLAW_NONE);
    push_frame(OP_LIGHT, 8'h02, {24'h0000FF, 24'h0}, FLAW_NONE);
    push_frame(OP_LIGHT, LIGHT_ON_ARG, 48'h0, FLAW_NONE);
    // address frames, a repeated all-ones address, then the zero address
    push_frame(OP_ADDR, 8'h00, {32'hFFFF_FFFF, 16'h0}, FLAW_NONE);
    push_frame(OP_ADDR, 8'hFF, {32'hFFFF_FFFF, 16'hFFFF}, FLAW_NONE);
    push_frame(OP_ADDR, 8'h00, 48'h0, FLAW_NONE);
    // unknown opcodes
    push_frame(8'h80, 8'h33, {16'h1234, 16'h5678, 16'h9ABC}, FLAW_NONE);
    push_frame(8'hFE, 8'hCC, 48'h0, FLAW_NONE);
    // rejected frames, then a good one right behind
    push_frame(OP_MOTION, 8'h11, {16'h0001, 16'h0002, 16'h0003}, FLAW_END);
    push_frame(OP_CHARGE, 8'h44, {16'h0004, 16'h0005, 16'h0006}, FLAW_CHECK);
    push_frame(OP_MOTION, 8'h22, 48'h0, FLAW_NONE);

    run_phase(8'd0, 8'd1, 0, 0, 7);
    run_phase(8'd3, 8'd2, 76, 0, 7);
    run_phase(8'd255, 8'd255, 0, 76, 7);
    // repeat one address between idle motion frames
    for (int i = 0; i < LONG_RUN; i++) begin
      push_frame(OP_ADDR, 8'($urandom), {addr_pool[1], 16'($urandom)}, FLAW_NONE);
      push_frame(OP_MOTION, 8'($urandom), 48'h0, FLAW_NONE);
    end
    run_phase(8'd2, 8'd0, 33, 33, 7);
    run_phase(8'($urandom), 8'($urandom_range(1, 255)), 0, 0, 6);
    settle();

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("serial_command_frame_parser_unit: match");
    end else begin
      $display("serial_command_frame_parser_unit: mismatch");
    end
    $finish;
  end

  // Hold-off limit for a hung run
  initial begin
    #1_000_000;
    $display("serial_command_frame_parser_unit: mismatch");
    $finish;
  end

endmodule

// ===== serial_command_frame_parser_unit.f =====
rtl/scfp_pkg.sv
rtl/scfp_if.sv
rtl/scfp_assembler.sv
rtl/scfp_decoder.sv
rtl/serial_command_frame_parser_unit.sv
dv/tb_serial_command_frame_parser_unit.sv
